// ===== hw/rtl/sgmr_pkg.sv =====
// Shared types and constants of the stencil gradient maximum block.
// No dependencies; every other file refers to it by scoped names.
package sgmr_pkg;

  localparam int CUBE_EDGE_DEF   = 12;
  localparam int GHOST_WIDTH_DEF = 2;
  localparam int DATA_W          = 32;
  localparam int DIFF_W          = DATA_W + 1;
  localparam int CFG_ADDR_W      = 3;

  localparam logic [DATA_W-1:0] COEFF_RESET = 32'h0001_0000;

  typedef enum logic {
    REG_FIVE_POINT = 1'b0,
    REG_COEFF      = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              five_point;
    logic [DATA_W-1:0] coeff;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic eval;
    logic start;
    logic last;
  } item_flags_t;

  // near: p[+1] - p[-1]; far: p[-t] - p[+t]
  typedef struct packed {
    logic signed [DIFF_W-1:0] near;
    logic signed [DIFF_W-1:0] far;
  } axis_diff_t;

endpackage

// ===== hw/rtl/sgmr_if.sv =====
// Valid/ready channel interfaces for sample requests and result requests.
// Depends on sgmr_pkg for the data width.
interface sgmr_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [sgmr_pkg::DATA_W-1:0] potential;
  logic                           level_start;
  logic                           level_end;

  modport source (output valid, potential, level_start, level_end, input ready);
  modport sink (input valid, potential, level_start, level_end, output ready);
endinterface

interface sgmr_out_if;
  logic                        valid;
  logic                        ready;
  logic [sgmr_pkg::DATA_W-1:0] max_accel;
  logic                        saturated;

  modport source (output valid, max_accel, saturated, input ready);
  modport sink (input valid, max_accel, saturated, output ready);
endinterface

// ===== hw/rtl/sgmr_cfg.sv =====
// APB-style register file: five-point mode and gradient coefficient.
// Depends on sgmr_pkg.
module sgmr_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sgmr_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [sgmr_pkg::DATA_W-1:0]          pwdata,
  output logic [sgmr_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  output sgmr_pkg::cfg_t                       cfg_o
);

  sgmr_pkg::cfg_t      cfg_q, cfg_d;
  sgmr_pkg::reg_idx_e  idx;
  logic                wr_en;

  assign idx    = sgmr_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        sgmr_pkg::REG_FIVE_POINT: cfg_d.five_point = pwdata[0];
        sgmr_pkg::REG_COEFF:      cfg_d.coeff      = pwdata;
        default:                  cfg_d            = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sgmr_pkg::REG_FIVE_POINT: prdata = {{(sgmr_pkg::DATA_W-1){1'b0}}, cfg_q.five_point};
      sgmr_pkg::REG_COEFF:      prdata = cfg_q.coeff;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.five_point <= 1'b0;
      cfg_q.coeff      <= sgmr_pkg::COEFF_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/sgmr_stencil.sv =====
// Raster position tracking, sample delay line and first difference stage.
// Depends on sgmr_pkg.
module sgmr_stencil #(
  parameter int CUBE_EDGE   = sgmr_pkg::CUBE_EDGE_DEF,
  parameter int GHOST_WIDTH = sgmr_pkg::GHOST_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic signed [sgmr_pkg::DATA_W-1:0]  potential_i,
  input  logic                                level_start_i,
  input  logic                                level_end_i,
  output sgmr_pkg::item_flags_t               flags_o,
  output sgmr_pkg::axis_diff_t                diff_o [3]
);

  localparam int PW    = CUBE_EDGE * CUBE_EDGE;
  localparam int CTR   = GHOST_WIDTH * PW;
  localparam int SR    = 2 * GHOST_WIDTH * PW;
  localparam int OUTER = (GHOST_WIDTH >= 2) ? 2 : 1;
  localparam int POS_W = $clog2(CUBE_EDGE);

  localparam logic [POS_W:0] G_L   = (POS_W+1)'(GHOST_WIDTH);
  localparam logic [POS_W:0] HI_L  = (POS_W+1)'(CUBE_EDGE - GHOST_WIDTH);
  localparam logic [POS_W:0] ZLO_L = (POS_W+1)'(2 * GHOST_WIDTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CUBE_EDGE - 1);

  logic [POS_W-1:0] col_q, row_q, pln_q, col_d, row_d, pln_d;
  logic [POS_W-1:0] col_c, row_c, pln_c;
  logic             eval_c;

  logic signed [sgmr_pkg::DATA_W-1:0] sr_q  [1:SR];
  logic signed [sgmr_pkg::DATA_W-1:0] tap_w [0:SR];

  sgmr_pkg::item_flags_t flags_q;
  sgmr_pkg::axis_diff_t  diff_q [3];

  // Level start restarts the raster before this sample.
  assign col_c = level_start_i ? '0 : col_q;
  assign row_c = level_start_i ? '0 : row_q;
  assign pln_c = level_start_i ? '0 : pln_q;

  assign eval_c = ({1'b0, col_c} >= G_L) && ({1'b0, col_c} < HI_L) &&
                  ({1'b0, row_c} >= G_L) && ({1'b0, row_c} < HI_L) &&
                  ({1'b0, pln_c} >= ZLO_L);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    pln_d = pln_q;
    if (accept_i) begin
      col_d = col_c + 1'b1;
      row_d = row_c;
      pln_d = pln_c;
      if (col_c == LAST_POS) begin
        col_d = '0;
        row_d = row_c + 1'b1;
        if (row_c == LAST_POS) begin
          row_d = '0;
          pln_d = (pln_c == LAST_POS) ? '0 : pln_c + 1'b1;
        end
      end
      if (level_end_i) begin
        col_d = '0;
        row_d = '0;
        pln_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      pln_q   <= '0;
      flags_q <= '0;
    end else begin
      col_q         <= col_d;
      row_q         <= row_d;
      pln_q         <= pln_d;
      flags_q.valid <= accept_i;
      flags_q.eval  <= eval_c;
      flags_q.start <= level_start_i;
      flags_q.last  <= level_end_i;
    end
  end

  // Tap k is the sample taken k requests before the current one.
  assign tap_w[0] = potential_i;
  for (genvar k = 1; k <= SR; k++) begin : g_tap
    assign tap_w[k] = sr_q[k];
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sr_q[1] <= potential_i;
      for (int k = 2; k <= SR; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    localparam int ST = (a == 0) ? 1 : ((a == 1) ? CUBE_EDGE : PW);
    always_ff @(posedge clk_i) begin
      diff_q[a].near <= {tap_w[CTR-ST][sgmr_pkg::DATA_W-1], tap_w[CTR-ST]}
                      - {tap_w[CTR+ST][sgmr_pkg::DATA_W-1], tap_w[CTR+ST]};
      diff_q[a].far  <= {tap_w[CTR+OUTER*ST][sgmr_pkg::DATA_W-1], tap_w[CTR+OUTER*ST]}
                      - {tap_w[CTR-OUTER*ST][sgmr_pkg::DATA_W-1], tap_w[CTR-OUTER*ST]};
    end
    assign diff_o[a] = diff_q[a];
  end

  assign flags_o = flags_q;

endmodule

// ===== hw/rtl/sgmr_deriv.sv =====
// One axis: combine differences, take magnitude, scale and saturate.
// Four register stages. Depends on sgmr_pkg.
module sgmr_deriv (
  input  logic                        clk_i,
  input  logic                        five_point_i,
  input  logic [sgmr_pkg::DATA_W-1:0] coeff_i,
  input  sgmr_pkg::axis_diff_t        diff_i,
  output logic [sgmr_pkg::DATA_W-1:0] val_o,
  output logic                        sat_o
);

  localparam int DW = sgmr_pkg::DIFF_W + 4;
  localparam int MW = DW - 1;
  localparam int HW = sgmr_pkg::DATA_W / 2;
  localparam int PW = MW + HW;

  logic signed [DW-1:0] d_q, d_c, neg_c;
  logic [MW-1:0]        mag_q;
  logic [PW-1:0]        hi_q, lo_q;
  logic [PW:0]          prod_c;
  logic [sgmr_pkg::DATA_W-1:0] val_q;
  logic                 sat_q;

  always_comb begin
    if (five_point_i) begin
      d_c = (DW'(diff_i.near) <<< 3) + DW'(diff_i.far);
    end else begin
      d_c = DW'(diff_i.near);
    end
  end

  assign neg_c  = -d_q;
  assign prod_c = {1'b0, hi_q} + {{(HW+1){1'b0}}, lo_q[PW-1:HW]};

  always_ff @(posedge clk_i) begin
    d_q   <= d_c;
    mag_q <= d_q[DW-1] ? neg_c[MW-1:0] : d_q[MW-1:0];
    hi_q  <= mag_q * coeff_i[sgmr_pkg::DATA_W-1:HW];
    lo_q  <= mag_q * coeff_i[HW-1:0];
    sat_q <= |prod_c[PW:sgmr_pkg::DATA_W];
    val_q <= (|prod_c[PW:sgmr_pkg::DATA_W]) ? '1 : prod_c[sgmr_pkg::DATA_W-1:0];
  end

  assign val_o = val_q;
  assign sat_o = sat_q;

endmodule

// ===== hw/rtl/stencil_gradient_max_reduce_core.sv =====
// A sample reaches the running maximum through the stencil and derivative registers;
// a level-end result is offered at the output from the edge that registers its maximum.
// Throughput: one sample per cycle, set by the fully pipelined stencil and scale path;
// input stalls while queued results plus level ends still in the pipeline number two.
// Reset clears position, maximum, saturation flag, queue and config; the delay line
// holds no reset state.
module stencil_gradient_max_reduce_core #(
  parameter int CUBE_EDGE   = sgmr_pkg::CUBE_EDGE_DEF,
  parameter int GHOST_WIDTH = sgmr_pkg::GHOST_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sgmr_in_if.sink                         in_ch,
  sgmr_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sgmr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sgmr_pkg::DATA_W-1:0]     pwdata,
  output logic [sgmr_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  localparam int DW = sgmr_pkg::DATA_W;

  sgmr_pkg::cfg_t        cfg;
  sgmr_pkg::item_flags_t st_flags;
  sgmr_pkg::item_flags_t dly_q [4];
  sgmr_pkg::axis_diff_t  diff [3];
  logic [DW-1:0]         val [3];
  logic [2:0]            sat;
  logic                  accept;

  logic [DW-1:0] rm_q, rm_d, base_max, m01;
  logic          sat_q, sat_d;
  logic          push, pop;

  logic [DW:0]   fifo_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic [2:0]    ends;

  sgmr_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  sgmr_stencil #(.CUBE_EDGE(CUBE_EDGE), .GHOST_WIDTH(GHOST_WIDTH)) u_stencil (
    .clk_i, .rst_ni,
    .accept_i      (accept),
    .potential_i   (in_ch.potential),
    .level_start_i (in_ch.level_start),
    .level_end_i   (in_ch.level_end),
    .flags_o       (st_flags),
    .diff_o        (diff)
  );

  for (genvar a = 0; a < 3; a++) begin : g_deriv
    sgmr_deriv u_deriv (
      .clk_i,
      .five_point_i (cfg.five_point),
      .coeff_i      (cfg.coeff),
      .diff_i       (diff[a]),
      .val_o        (val[a]),
      .sat_o        (sat[a])
    );
  end

  // Reserve queue space for every level end still in the pipeline.
  assign ends = 3'($countones({st_flags.valid & st_flags.last,
                               dly_q[0].valid & dly_q[0].last,
                               dly_q[1].valid & dly_q[1].last,
                               dly_q[2].valid & dly_q[2].last,
                               dly_q[3].valid & dly_q[3].last}));
  assign in_ch.ready = ({1'b0, cnt_q} + ends) < 3'd2;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) dly_q[i] <= '0;
    end else begin
      dly_q[0] <= st_flags;
      for (int i = 1; i < 4; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  assign base_max = dly_q[3].start ? '0 : rm_q;
  assign m01      = (val[1] > val[0]) ? val[1] : val[0];

  always_comb begin
    rm_d  = rm_q;
    sat_d = sat_q;
    if (dly_q[3].valid) begin
      rm_d  = base_max;
      sat_d = dly_q[3].start ? 1'b0 : sat_q;
      if (dly_q[3].eval) begin
        if (val[2] > m01) begin
          if (val[2] > base_max) rm_d = val[2];
        end else if (m01 > base_max) begin
          rm_d = m01;
        end
        sat_d = sat_d | (|sat);
      end
    end
  end

  assign push = dly_q[3].valid && dly_q[3].last;
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rm_q  <= '0;
      sat_q <= 1'b0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      rm_q  <= rm_d;
      sat_q <= sat_d;
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= {sat_d, rm_d};
  end

  assign out_ch.valid     = cnt_q != 2'd0;
  assign out_ch.max_accel = fifo_q[rd_q][DW-1:0];
  assign out_ch.saturated = fifo_q[rd_q][DW];

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result queue overflow");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push)
    else $error("result pushed into full queue");

  a_max_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dly_q[3].valid && !dly_q[3].start) |=> rm_q >= $past(rm_q))
    else $error("running maximum decreased within a level");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (rm_q == '1))
    else $error("saturation seen without saturated maximum");
`endif

endmodule
